/* rtl/core/decimal_string_to_exit_code_core_macros.svh */
// Assertion macros used by the decimal string parser core.
`ifndef DECIMAL_STRING_TO_EXIT_CODE_CORE_MACROS_SVH
`define DECIMAL_STRING_TO_EXIT_CODE_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define DSEC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dsec assertion failed");

// Check that cons holds in the cycle after ante.
`define DSEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dsec assertion failed");

`endif

/* rtl/core/dsec_pkg.sv */
// Types, character codes and limits for the decimal string parser.
package dsec_pkg;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DIGITS,
    PH_TRAIL,
    PH_BAD
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic        is_negative;
    logic [63:0] value_accum;
    logic [4:0]  digit_count;
  } state_t;

  localparam logic [7:0] NulChar   = 8'd0;
  localparam logic [7:0] TabChar   = 8'd9;
  localparam logic [7:0] CrChar    = 8'd13;
  localparam logic [7:0] SpaceChar = 8'd32;
  localparam logic [7:0] PlusChar  = 8'd43;
  localparam logic [7:0] MinusChar = 8'd45;
  localparam logic [7:0] ZeroChar  = 8'd48;
  localparam logic [7:0] NineChar  = 8'd57;

  localparam logic [4:0] MaxDigits = 5'd19;
  localparam logic [4:0] CountSat  = 5'd20;
  localparam logic [7:0] BadCode   = 8'd255;

  localparam state_t StateReset = '{
    phase:       PH_LEAD,
    is_negative: 1'b0,
    value_accum: 64'd0,
    digit_count: 5'd0
  };

  function automatic logic is_space(input logic [7:0] c);
    return ((c >= TabChar) && (c <= CrChar)) || (c == SpaceChar);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ZeroChar) && (c <= NineChar);
  endfunction

endpackage

/* rtl/core/decimal_string_to_exit_code_core.sv */
// Decimal string parser: one character in per word, one exit code out per string.
//
// Input channel: in_valid/in_ready carry one character word (ch). A zero byte
// ends the string. Leading and trailing whitespace, one optional sign and up
// to 19 decimal digits form a valid string.
// Output channel: out_valid/out_ready carry one result word per string:
// exit_code holds the low byte of the signed value, or 255 with not_numeric
// set when the string is not a valid signed 64-bit decimal.
// Throughput: one character per cycle, except that a terminator waits while
// the output register is full. The 64-bit times-ten shift-add that folds a digit
// into the accumulator is combinational from the state register back to itself.
// Latency: the result word is valid in the cycle after the terminator is
// accepted. Characters produce no word.
// Stall: the result stays in the output register until taken. Non-terminator
// characters are still accepted meanwhile; a terminator waits until the
// output register is free or being emptied in the same cycle.
// Reset (rst, synchronous): parser returns to the leading whitespace phase
// with a cleared accumulator, and the output register is emptied.
`include "decimal_string_to_exit_code_core_macros.svh"

module decimal_string_to_exit_code_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] exit_code,
  output logic       not_numeric
);

  dsec_pkg::state_t st;
  dsec_pkg::state_t st_next;
  logic             in_fire;
  logic             is_term;
  logic [7:0]       code_next;
  logic             flag_next;

  assign is_term  = (ch == dsec_pkg::NulChar);
  assign in_ready = !out_valid || out_ready || !is_term;
  assign in_fire  = in_valid && in_ready;

  dsec_step u_step (
    .ch          (ch),
    .cur         (st),
    .nxt         (st_next),
    .exit_code   (code_next),
    .not_numeric (flag_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= dsec_pkg::StateReset;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && is_term) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // load the result word on the terminator
  always_ff @(posedge clk) begin
    if (in_fire && is_term) begin
      exit_code   <= code_next;
      not_numeric <= flag_next;
    end
  end

  `DSEC_ASSERT_NEXT(a_term_gives_word, in_fire && is_term, out_valid)
  `DSEC_ASSERT_NEXT(a_term_restarts, in_fire && is_term, st == dsec_pkg::StateReset)
  `DSEC_ASSERT_NOW(a_bad_code, out_valid && not_numeric, exit_code == dsec_pkg::BadCode)
  `DSEC_ASSERT_NOW(a_count_sat, 1'b1, st.digit_count <= dsec_pkg::CountSat)

endmodule

/* rtl/core/dsec_step.sv */
// Per-character parser step: next state and the result for a terminator.
module dsec_step (
  input  logic [7:0]       ch,
  input  dsec_pkg::state_t cur,
  output dsec_pkg::state_t nxt,
  output logic [7:0]       exit_code,
  output logic             not_numeric
);

  logic                 dig;
  logic                 spc;
  logic                 sgn;
  logic                 take;
  logic [7:0]           ch_off;
  logic [63:0]          acc_step;
  dsec_pkg::phase_t     phase_next;
  logic                 neg_next;
  logic [63:0]          acc_next;
  logic [4:0]           count_next;
  logic [7:0]           neg_low;
  logic                 range_bad;

  assign dig    = dsec_pkg::is_digit(ch);
  assign spc    = dsec_pkg::is_space(ch);
  assign sgn    = (ch == dsec_pkg::PlusChar) || (ch == dsec_pkg::MinusChar);
  assign ch_off = ch - dsec_pkg::ZeroChar;

  // times ten as x*8 + x*2, then add the digit
  assign acc_step = {cur.value_accum[60:0], 3'b000} + {cur.value_accum[62:0], 1'b0}
                  + {60'd0, ch_off[3:0]};

  // next phase, sign and digit-take flag
  always_comb begin
    phase_next = cur.phase;
    take       = 1'b0;
    neg_next   = cur.is_negative;
    unique case (cur.phase) inside
      dsec_pkg::PH_LEAD: begin
        if (spc) begin
          phase_next = dsec_pkg::PH_LEAD;
        end else if (sgn) begin
          neg_next   = (ch == dsec_pkg::MinusChar);
          phase_next = dsec_pkg::PH_SIGN;
        end else if (dig) begin
          take       = 1'b1;
          phase_next = dsec_pkg::PH_DIGITS;
        end else begin
          phase_next = dsec_pkg::PH_BAD;
        end
      end
      dsec_pkg::PH_SIGN, dsec_pkg::PH_DIGITS: begin
        if (dig) begin
          take       = 1'b1;
          phase_next = dsec_pkg::PH_DIGITS;
        end else if (spc) begin
          phase_next = dsec_pkg::PH_TRAIL;
        end else begin
          phase_next = dsec_pkg::PH_BAD;
        end
      end
      dsec_pkg::PH_TRAIL: begin
        phase_next = spc ? dsec_pkg::PH_TRAIL : dsec_pkg::PH_BAD;
      end
      default: begin
        phase_next = dsec_pkg::PH_BAD;
      end
    endcase
  end

  // data path and result
  always_comb begin
    acc_next   = take ? acc_step : cur.value_accum;
    count_next = cur.digit_count;
    if (take && (cur.digit_count < dsec_pkg::CountSat)) begin
      count_next = cur.digit_count + 5'd1;
    end

    range_bad = cur.is_negative ? (cur.value_accum[63] && (|cur.value_accum[62:0]))
                                : cur.value_accum[63];
    not_numeric = (cur.phase == dsec_pkg::PH_LEAD) || (cur.phase == dsec_pkg::PH_SIGN)
               || (cur.phase == dsec_pkg::PH_BAD)
               || (cur.digit_count > dsec_pkg::MaxDigits) || range_bad;
    neg_low   = 8'd0 - cur.value_accum[7:0];
    exit_code = not_numeric ? dsec_pkg::BadCode
              : (cur.is_negative ? neg_low : cur.value_accum[7:0]);
  end

  // a terminator returns to the start phase
  assign nxt = (ch == dsec_pkg::NulChar) ? dsec_pkg::StateReset
             : '{phase: phase_next, is_negative: neg_next,
                 value_accum: acc_next, digit_count: count_next};

endmodule

/* verif/tb_decimal_string_to_exit_code_core.sv */
// Self-checking testbench for the decimal string parser core.
module tb_decimal_string_to_exit_code_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] code;
    logic       flag;
  } exit_result_t;

  typedef enum int {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_SPARSE,
    READY_RARE
  } ready_mode_t;

  typedef enum int {
    STR_NUMBER,
    STR_BROKEN,
    STR_SIGN_BLANK,
    STR_NOISE,
    STR_BLANK
  } string_kind_t;

  localparam logic [63:0] PosLimit = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegLimit = 64'h8000_0000_0000_0000;
  localparam int          RandomChars = 1400;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] ch = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] exit_code;
  logic       not_numeric;

  decimal_string_to_exit_code_core uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .exit_code  (exit_code),
    .not_numeric(not_numeric)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [7:0]   pending_chars[$];
  exit_result_t expected_codes[$];
  int           mismatch_count = 0;
  bit           in_accepted = 1'b0;

  // Parser shadow state
  dsec_pkg::phase_t pr_phase = dsec_pkg::PH_LEAD;
  logic             pr_neg = 1'b0;
  logic [63:0]      pr_accum = 64'd0;
  logic [4:0]       pr_count = 5'd0;

  task automatic fold_digit(input logic [7:0] c);
    pr_accum = pr_accum * 64'd10 + {56'd0, c - dsec_pkg::ZeroChar};
    if (pr_count < dsec_pkg::CountSat) pr_count = pr_count + 5'd1;
    pr_phase = dsec_pkg::PH_DIGITS;
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic         blank;
    logic         digit;
    logic         bad;
    logic [63:0]  signed_val;
    exit_result_t res;
    blank = ((c >= dsec_pkg::TabChar) && (c <= dsec_pkg::CrChar)) ||
            (c == dsec_pkg::SpaceChar);
    digit = (c >= dsec_pkg::ZeroChar) && (c <= dsec_pkg::NineChar);
    if (c == dsec_pkg::NulChar) begin
      bad = (pr_phase == dsec_pkg::PH_LEAD) || (pr_phase == dsec_pkg::PH_SIGN) ||
            (pr_phase == dsec_pkg::PH_BAD) || (pr_count > dsec_pkg::MaxDigits) ||
            (!pr_neg && (pr_accum > PosLimit)) || (pr_neg && (pr_accum > NegLimit));
      signed_val = pr_neg ? (64'd0 - pr_accum) : pr_accum;
      res.code = bad ? dsec_pkg::BadCode : signed_val[7:0];
      res.flag = bad;
      expected_codes.push_back(res);
      pr_phase = dsec_pkg::PH_LEAD;
      pr_neg   = 1'b0;
      pr_accum = 64'd0;
      pr_count = 5'd0;
    end else begin
      case (pr_phase)
        dsec_pkg::PH_LEAD: begin
          if (blank) begin
          end else if ((c == dsec_pkg::PlusChar) || (c == dsec_pkg::MinusChar)) begin
            pr_neg   = (c == dsec_pkg::MinusChar);
            pr_phase = dsec_pkg::PH_SIGN;
          end else if (digit) begin
            fold_digit(c);
          end else begin
            pr_phase = dsec_pkg::PH_BAD;
          end
        end
        dsec_pkg::PH_SIGN, dsec_pkg::PH_DIGITS: begin
          if (digit) fold_digit(c);
          else if (blank) pr_phase = dsec_pkg::PH_TRAIL;
          else pr_phase = dsec_pkg::PH_BAD;
        end
        dsec_pkg::PH_TRAIL: begin
          if (!blank) pr_phase = dsec_pkg::PH_BAD;
        end
        default: pr_phase = dsec_pkg::PH_BAD;
      endcase
    end
  endtask

  // Sample accepted words on both channels
  always @(posedge clk) begin : monitor
    exit_result_t want;
    in_accepted = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_accepted = 1'b1;
        parse_char(ch);
      end
      if (out_valid && out_ready) begin
        if (expected_codes.size() == 0) begin
          $error("unexpected result word: exit_code=%0d not_numeric=%0d",
                 exit_code, not_numeric);
          mismatch_count++;
        end else begin
          want = expected_codes.pop_front();
          if (exit_code !== want.code) begin
            $error("exit_code: expected %0d, got %0d", want.code, exit_code);
            mismatch_count++;
          end
          if (not_numeric !== want.flag) begin
            $error("not_numeric: expected %0d, got %0d", want.flag, not_numeric);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Sender: bursts of words separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_accepted) begin
      // hold the word until taken
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_chars.size() > 0) begin
      in_valid <= 1'b1;
      ch <= pending_chars.pop_front();
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: stall pattern switches between a few modes
  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left = 0;
  int          ready_tick = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      ready_tick++;
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        READY_SPARSE: out_ready <= ((ready_tick % 5) == 0);
        default:      out_ready <= ((ready_tick % 17) == 0);
      endcase
    end
  end

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
    pending_chars.push_back(dsec_pkg::NulChar);
  endtask

  function automatic string blank_run(input int n);
    string s;
    int    c;
    s = "";
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(9, 14);
      if (c == 14) c = dsec_pkg::SpaceChar;
      s = {s, $sformatf("%c", c[7:0])};
    end
    return s;
  endfunction

  function automatic string digit_text();
    string       s;
    logic [63:0] val;
    int          sel;
    s = "";
    sel = $urandom_range(0, 9);
    if (sel <= 5) begin
      s = $sformatf("%0d", $urandom_range(0, 999));
    end else if (sel == 6) begin
      val = {$urandom, $urandom};
      s = $sformatf("%0d", val);
    end else if (sel == 7) begin
      // straddle the signed 64-bit limits
      val = PosLimit - 64'd1 + 64'($urandom_range(0, 3));
      s = $sformatf("%0d", val);
    end else if (sel == 8) begin
      // long run of leading zeros can drive the digit count past its limit
      repeat ($urandom_range(15, 22)) s = {s, "0"};
      s = {s, $sformatf("%0d", $urandom_range(0, 99))};
    end else begin
      repeat ($urandom_range(18, 21)) s = {s, "9"};
    end
    return s;
  endfunction

  function automatic string sign_text();
    case ($urandom_range(0, 2))
      0:       return "";
      1:       return "+";
      default: return "-";
    endcase
  endfunction

  function automatic string number_text();
    return {blank_run($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0), sign_text(),
            digit_text(), blank_run($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0)};
  endfunction

  initial begin : stimulus
    string        s;
    string        sg;
    string_kind_t kind;
    int           pos;
    int           n;

    // Directed strings
    append_text("");
    append_text("\t \015");
    append_text("-");
    append_text("+ ");
    append_text("7x");
    append_text("+-1");
    append_text("1 2");
    append_text("0");
    pending_chars.push_back(8'hFF);
    pending_chars.push_back(dsec_pkg::NulChar);

    n = pending_chars.size() + RandomChars;
    while (pending_chars.size() < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: kind = STR_NUMBER;
        5, 6:          kind = STR_BROKEN;
        7:             kind = STR_SIGN_BLANK;
        8:             kind = STR_NOISE;
        default:       kind = STR_BLANK;
      endcase
      case (kind)
        STR_NUMBER: s = number_text();
        STR_BROKEN: begin
          // corrupt one character of a well-formed string
          s = number_text();
          pos = $urandom_range(0, s.len() - 1);
          s[pos] = $urandom_range(1, 255);
        end
        STR_SIGN_BLANK: begin
          sg = "-";
          if ($urandom_range(0, 1) == 0) sg = "+";
          s = {sg, blank_run($urandom_range(0, 3))};
        end
        STR_NOISE: begin
          s = "";
          repeat ($urandom_range(1, 6)) s = {s, $sformatf("%c", 8'($urandom_range(1, 255)))};
        end
        default: s = blank_run($urandom_range(0, 4));
      endcase
      append_text(s);
    end
  end

  initial begin : sequencer
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while ((pending_chars.size() != 0) || in_valid) @(posedge clk);
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("decimal_string_to_exit_code_core regression: pass");
    end else begin
      $display("decimal_string_to_exit_code_core regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("decimal_string_to_exit_code_core regression: fail");
    $finish;
  end

endmodule
